// ===== sv/strsb_pkg.sv =====
`default_nettype none

package strsb_pkg;

    localparam int unsigned POC_W    = 31;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned NNEG_W   = 5;
    localparam int unsigned LIMIT_W  = 5;
    localparam int unsigned LIMIT_RST = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT,
        S_IDR,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                 is_idr;
        logic [IDX_W-1:0]     entry_index;
        logic [DELTA_W-1:0]   delta_minus_one;
        logic [NNEG_W-1:0]    negative_count;
        logic [SLOT_W-1:0]    list_slot;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/short_term_ref_set_builder.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// request   | i_valid / o_ready    | i_pic_count, i_target_slot, i_has_reference,
//           |                      | i_reference_slot
// result    | o_valid / i_ready    | o_is_idr, o_entry_index, o_delta_minus_one,
//           |                      | o_negative_count, o_list_slot, o_last
// config    | i_cfg_we             | i_cfg_data (history depth limit)
//
// A request first walks the history with one shared comparator, one entry a cycle; then
// one shared subtractor forms one result a cycle while the result register is free (an
// IDR request gives a single result instead), then the S_UPDATE state updates the state.
// The result register holds a result while i_ready is low; each new result waits on it.
// o_ready is high only between requests. Reset is synchronous and active low;
// it clears the history fill and the slot valid bits, no clearing pass.
`default_nettype none

module short_term_ref_set_builder #(
    parameter int unsigned HISTORY_DEPTH = 16,
    parameter int unsigned SLOT_COUNT    = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [strsb_pkg::LIMIT_W-1:0]      i_cfg_data,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire [strsb_pkg::POC_W-1:0]        i_pic_count,
    input  wire [strsb_pkg::SLOT_W-1:0]       i_target_slot,
    input  wire                               i_has_reference,
    input  wire [strsb_pkg::SLOT_W-1:0]       i_reference_slot,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic                              o_is_idr,
    output logic [strsb_pkg::IDX_W-1:0]       o_entry_index,
    output logic [strsb_pkg::DELTA_W-1:0]     o_delta_minus_one,
    output logic [strsb_pkg::NNEG_W-1:0]      o_negative_count,
    output logic [strsb_pkg::SLOT_W-1:0]      o_list_slot,
    output logic                              o_last
);

    localparam int unsigned HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned WW  = 6;

    strsb_pkg::t_state  r_state, n_state;

    logic [strsb_pkg::LIMIT_W-1:0] r_limit;
    logic [FW-1:0]                 r_fill, n_fill;
    logic [FW-1:0]                 r_idx, n_idx;
    logic [FW-1:0]                 r_nneg, n_nneg;
    logic                          r_out_valid, n_out_valid;
    strsb_pkg::t_result            r_out, n_out;

    logic [strsb_pkg::POC_W-1:0]   r_poc;
    logic [strsb_pkg::SLOT_W-1:0]  r_tslot;
    logic [strsb_pkg::SLOT_W-1:0]  r_rslot;
    logic [strsb_pkg::POC_W-1:0]   r_ref;
    logic                          r_want;

    logic [strsb_pkg::POC_W-1:0]   r_hist     [HISTORY_DEPTH];
    logic [strsb_pkg::POC_W-1:0]   r_slot_cnt [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]         r_slot_vld;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_ref_in_range;
    logic [SW-1:0]                 w_rsel;
    logic [SW-1:0]                 w_tsel;
    logic                          w_tslot_in_range;
    logic [strsb_pkg::POC_W-1:0]   w_ref_val;
    logic [strsb_pkg::POC_W-1:0]   w_hist_rd;
    logic [FW-1:0]                 w_idx_inc;
    logic                          w_push;
    logic                          w_hist_push;
    logic                          w_slot_we;
    logic [WW-1:0]                 w_f1, w_f2, w_f3, w_lim;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    assign w_ref_in_range   = 32'(i_reference_slot) < 32'(SLOT_COUNT);
    assign w_tslot_in_range = 32'(r_tslot) < 32'(SLOT_COUNT);
    assign w_rsel           = SW'(i_reference_slot);
    assign w_tsel           = SW'(r_tslot);
    assign w_ref_val        = r_slot_vld[w_rsel] ? r_slot_cnt[w_rsel] : '0;
    assign w_hist_rd        = r_hist[r_idx[HIW-1:0]];
    assign w_idx_inc        = r_idx + FW'(1);

    assign w_push = (r_fill == '0) || (r_hist[0] != r_poc);
    assign w_f1   = WW'(r_fill) + (w_push ? WW'(1) : WW'(0));
    assign w_lim  = (WW'(r_limit) > WW'(HISTORY_DEPTH)) ? WW'(HISTORY_DEPTH) : WW'(r_limit);
    assign w_f2   = (w_f1 > w_lim) ? (w_f1 - WW'(1)) : w_f1;
    assign w_f3   = (w_f2 > WW'(HISTORY_DEPTH)) ? WW'(HISTORY_DEPTH) : w_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= strsb_pkg::S_IDLE;
            r_limit     <= strsb_pkg::LIMIT_W'(strsb_pkg::LIMIT_RST);
            r_fill      <= '0;
            r_idx       <= '0;
            r_nneg      <= '0;
            r_out_valid <= 1'b0;
            r_slot_vld  <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_nneg      <= n_nneg;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (w_slot_we) begin
                r_slot_vld[w_tsel] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_poc   <= i_pic_count;
            r_tslot <= i_target_slot;
            r_rslot <= i_reference_slot;
            r_ref   <= w_ref_val;
            r_want  <= i_has_reference && w_ref_in_range;
        end
        if (w_slot_we) begin
            r_slot_cnt[w_tsel] <= r_poc;
        end
        if (w_hist_push) begin
            for (int k = 1; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_hist[0] <= r_poc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_nneg      = r_nneg;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_ready     = 1'b0;
        w_hist_push = 1'b0;
        w_slot_we   = 1'b0;
        case (r_state)
            strsb_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_idx   = '0;
                    n_state = strsb_pkg::S_SEARCH;
                end
            end
            strsb_pkg::S_SEARCH: begin
                if (!r_want || r_idx == r_fill) begin
                    n_state = strsb_pkg::S_IDR;
                end else if (w_hist_rd == r_ref) begin
                    n_nneg  = w_idx_inc;
                    n_idx   = '0;
                    n_state = strsb_pkg::S_EMIT;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            strsb_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.is_idr          = 1'b0;
                    n_out.entry_index     = strsb_pkg::IDX_W'(r_idx);
                    n_out.delta_minus_one = strsb_pkg::DELTA_W'(r_poc[15:0]
                                            - w_hist_rd[15:0]
                                            - strsb_pkg::DELTA_W'(r_idx)
                                            - strsb_pkg::DELTA_W'(1));
                    n_out.negative_count  = strsb_pkg::NNEG_W'(r_nneg);
                    n_out.list_slot       = r_rslot;
                    n_out.last            = (w_idx_inc == r_nneg);
                    n_idx                 = w_idx_inc;
                    if (w_idx_inc == r_nneg) begin
                        n_state = strsb_pkg::S_UPDATE;
                    end
                end
            end
            strsb_pkg::S_IDR: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.is_idr          = 1'b1;
                    n_out.entry_index     = '0;
                    n_out.delta_minus_one = '0;
                    n_out.negative_count  = '0;
                    n_out.list_slot       = '0;
                    n_out.last            = 1'b1;
                    n_fill                = '0;
                    n_state               = strsb_pkg::S_UPDATE;
                end
            end
            strsb_pkg::S_UPDATE: begin
                w_slot_we   = w_tslot_in_range;
                w_hist_push = w_push;
                n_fill      = FW'(w_f3);
                n_state     = strsb_pkg::S_IDLE;
            end
            default: begin
                n_state = strsb_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_is_idr          = r_out.is_idr;
    assign o_entry_index     = r_out.entry_index;
    assign o_delta_minus_one = r_out.delta_minus_one;
    assign o_negative_count  = r_out.negative_count;
    assign o_list_slot       = r_out.list_slot;
    assign o_last            = r_out.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= HISTORY_DEPTH)
        else $error("history fill above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("ready right after an accepted request");

    a_emit_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strsb_pkg::S_EMIT) |-> (r_idx < r_nneg))
        else $error("emit index beyond the set");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_idr && o_last) |->
            (strsb_pkg::NNEG_W'(o_entry_index) + strsb_pkg::NNEG_W'(1) == o_negative_count))
        else $error("final P result does not close the set");

    a_idr_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_idr) |-> (o_last && o_negative_count == '0))
        else $error("IDR result not a single closing result");

endmodule

`default_nettype wire
